FILE: src/multi_ant_turmite_step_core_defines.svh
// Assertion helpers; clk and arst_n must be visible where they are used.
`ifndef MULTI_ANT_TURMITE_STEP_CORE_DEFINES_SVH
`define MULTI_ANT_TURMITE_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define MAT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MAT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mat_pkg.sv
`default_nettype none

package mat_pkg;

	localparam int OP_W         = 2;
	localparam int SLOT_W       = 4;
	localparam int COORD_W      = 8;
	localparam int HEAD_W       = 2;
	localparam int RGB_W        = 24;
	localparam int PIX_IDX_W    = 16;
	localparam int PIX_COLOR_W  = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;
	localparam int SIZE_REG_W   = 9;
	localparam int COUNT_REG_W  = 5;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic [SIZE_REG_W-1:0]  COLS_RST  = 9'd256;
	localparam logic [SIZE_REG_W-1:0]  ROWS_RST  = 9'd256;
	localparam logic [COUNT_REG_W-1:0] COUNT_RST = 5'd16;

	localparam logic [HEAD_W-1:0] HD_UP    = 2'd0;
	localparam logic [HEAD_W-1:0] HD_RIGHT = 2'd1;
	localparam logic [HEAD_W-1:0] HD_DOWN  = 2'd2;
	localparam logic [HEAD_W-1:0] HD_LEFT  = 2'd3;

	localparam logic [PIX_COLOR_W-1:0] BLACK_ARGB = 32'hFF00_0000;

	// grid storage word
	localparam int GRID_WORD_W = 32;
	localparam int GRID_BIT_W  = 5;

	typedef struct packed {
		logic ld_wr;     // write ant slot from request
		logic cnt_rst;   // restart ant counter, read ant 0
		logic pos_ld;    // latch position, compute cell index
		logic mod_start; // reduce position modulo grid size
		logic idx_ld;    // compute cell index from reduced position
		logic grid_rd;   // read grid word
		logic commit;    // write back cell/ant, emit pixel, read next ant
		logic clr_rst;   // restart clear sweep
		logic clr_wr;    // clear one grid word
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic in_range;
		logic mod_done;
		logic last_ant;
		logic out_free;
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/mat_item_if.sv
`default_nettype none

interface mat_item_if import mat_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [SLOT_W-1:0]  ant_slot;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [HEAD_W-1:0]  start_heading;
	logic [RGB_W-1:0]   ant_rgb;

	modport source (output valid, operation, ant_slot, start_x, start_y, start_heading,
		ant_rgb, input ready);
	modport sink (input valid, operation, ant_slot, start_x, start_y, start_heading,
		ant_rgb, output ready);
endinterface

`default_nettype wire

FILE: src/mat_pixel_if.sv
`default_nettype none

interface mat_pixel_if import mat_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [PIX_IDX_W-1:0]   pixel_index;
	logic [PIX_COLOR_W-1:0] pixel_color;
	logic                   last_write;

	modport source (output valid, pixel_index, pixel_color, last_write, input ready);
	modport sink (input valid, pixel_index, pixel_color, last_write, output ready);
endinterface

`default_nettype wire

FILE: src/mat_cfg_if.sv
`default_nettype none

interface mat_cfg_if import mat_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/mat_mod_unit.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module mat_mod_unit #(
	parameter int DVD_W = 8,
	parameter int DIV_W = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DVD_W-1]};
		rem_sub = rem_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, divisor})
				rem_q <= rem_sub[DIV_W-1:0];
			else
				rem_q <= rem_sh[DIV_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[DVD_W-1:0];

endmodule

`default_nettype wire

FILE: src/mat_dp.sv
`default_nettype none

`include "multi_ant_turmite_step_core_defines.svh"

module mat_dp import mat_pkg::*; #(
	parameter int MAX_ANTS = 16,
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output sts_t                        sts,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [SLOT_W-1:0]      ant_slot,
	input  wire logic [COORD_W-1:0]     start_x,
	input  wire logic [COORD_W-1:0]     start_y,
	input  wire logic [HEAD_W-1:0]      start_heading,
	input  wire logic [RGB_W-1:0]       ant_rgb,
	output logic                        pixel_valid,
	input  wire logic                   pixel_ready,
	output logic [PIX_IDX_W-1:0]        pixel_index,
	output logic [PIX_COLOR_W-1:0]      pixel_color,
	output logic                        last_write
);

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int XW     = (CCNT_W > COORD_W) ? CCNT_W : COORD_W;
	localparam int YW     = (RCNT_W > COORD_W) ? RCNT_W : COORD_W;
	localparam int AW     = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
	localparam int NW     = $clog2(MAX_ANTS + 1);
	localparam int CELLS  = MAX_COLS * MAX_ROWS;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int PW     = ROW_W + CCNT_W;
	localparam int GD     = (CELLS + GRID_WORD_W - 1) / GRID_WORD_W;
	localparam int GAW    = (GD > 1) ? $clog2(GD) : 1;
	localparam int EW     = IDX_W + GRID_BIT_W;

	// configuration
	logic [SIZE_REG_W-1:0]  cols_raw_q;
	logic [SIZE_REG_W-1:0]  rows_raw_q;
	logic [COUNT_REG_W-1:0] count_raw_q;
	logic [CCNT_W-1:0]      cols_eff;
	logic [RCNT_W-1:0]      rows_eff;
	logic [NW-1:0]          n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_raw_q  <= COLS_RST;
			rows_raw_q  <= ROWS_RST;
			count_raw_q <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLS:  cols_raw_q  <= cfg_data[SIZE_REG_W-1:0];
				CFG_ROWS:  rows_raw_q  <= cfg_data[SIZE_REG_W-1:0];
				CFG_COUNT: count_raw_q <= cfg_data[COUNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_raw_q == '0)
			cols_eff = CCNT_W'(1);
		else if (32'(cols_raw_q) > MAX_COLS)
			cols_eff = CCNT_W'(MAX_COLS);
		else
			cols_eff = CCNT_W'(cols_raw_q);

		if (rows_raw_q == '0)
			rows_eff = RCNT_W'(1);
		else if (32'(rows_raw_q) > MAX_ROWS)
			rows_eff = RCNT_W'(MAX_ROWS);
		else
			rows_eff = RCNT_W'(rows_raw_q);

		if (32'(count_raw_q) > MAX_ANTS)
			n_eff = NW'(MAX_ANTS);
		else
			n_eff = NW'(count_raw_q);
	end

	// ant slots
	logic [COL_W-1:0]  ant_col_mem   [MAX_ANTS];
	logic [ROW_W-1:0]  ant_row_mem   [MAX_ANTS];
	logic [HEAD_W-1:0] ant_hd_mem    [MAX_ANTS];
	logic [RGB_W-1:0]  ant_paint_mem [MAX_ANTS];
	logic [COL_W-1:0]  ant_col_q;
	logic [ROW_W-1:0]  ant_row_q;
	logic [HEAD_W-1:0] ant_hd_q;
	logic [RGB_W-1:0]  ant_paint_q;

	logic [NW-1:0] a_q;
	logic [NW-1:0] a_inc;
	logic [AW-1:0] ant_raddr;
	logic          last_ant;
	logic          slot_ok;
	logic [XW-1:0] x_ext;
	logic [XW-1:0] x_max;
	logic [XW-1:0] x_cl;
	logic [YW-1:0] y_ext;
	logic [YW-1:0] y_max;
	logic [YW-1:0] y_cl;

	always_comb begin
		a_inc     = a_q + NW'(1);
		last_ant  = (a_inc == n_eff);
		ant_raddr = (cmd.cnt_rst || last_ant) ? '0 : a_inc[AW-1:0];
		slot_ok   = (32'(ant_slot) < MAX_ANTS);
		x_ext     = XW'(start_x);
		x_max     = XW'(cols_eff - CCNT_W'(1));
		x_cl      = (x_ext > x_max) ? x_max : x_ext;
		y_ext     = YW'(start_y);
		y_max     = YW'(rows_eff - RCNT_W'(1));
		y_cl      = (y_ext > y_max) ? y_max : y_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			a_q <= '0;
		else if (cmd.cnt_rst)
			a_q <= '0;
		else if (cmd.commit)
			a_q <= a_inc;
	end

	// position after reduction
	logic [COL_W-1:0]  c_q;
	logic [ROW_W-1:0]  r_q;
	logic [IDX_W-1:0]  idx_q;
	logic [COL_W-1:0]  c_mod;
	logic [ROW_W-1:0]  r_mod;
	logic              c_done;
	logic              r_done;
	logic [COL_W-1:0]  mul_c;
	logic [ROW_W-1:0]  mul_r;
	logic [PW-1:0]     prod;

	mat_mod_unit #(.DVD_W(COL_W), .DIV_W(CCNT_W)) u_col_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (ant_col_q),
		.divisor   (cols_eff),
		.done      (c_done),
		.remainder (c_mod)
	);

	mat_mod_unit #(.DVD_W(ROW_W), .DIV_W(RCNT_W)) u_row_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (ant_row_q),
		.divisor   (rows_eff),
		.done      (r_done),
		.remainder (r_mod)
	);

	always_comb begin
		mul_c = cmd.idx_ld ? c_mod : ant_col_q;
		mul_r = cmd.idx_ld ? r_mod : ant_row_q;
		prod  = PW'(mul_r) * PW'(cols_eff) + PW'(mul_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_ld || cmd.idx_ld) begin
			c_q   <= mul_c;
			r_q   <= mul_r;
			idx_q <= prod[IDX_W-1:0];
		end
	end

	// grid, one bit per cell, packed into words
	logic [GRID_WORD_W-1:0] grid_mem [GD];
	logic [GRID_WORD_W-1:0] gword_q;
	logic [GRID_WORD_W-1:0] gword_new;
	logic [EW-1:0]          idx_ext;
	logic [GAW-1:0]         gaddr;
	logic [GRID_BIT_W-1:0]  bsel;
	logic                   cell_bit;
	logic [GAW-1:0]         clr_q;
	logic                   clr_last;

	always_comb begin
		idx_ext   = EW'(idx_q);
		gaddr     = GAW'(idx_ext >> GRID_BIT_W);
		bsel      = idx_ext[GRID_BIT_W-1:0];
		cell_bit  = gword_q[bsel];
		gword_new = gword_q ^ (GRID_WORD_W'(1) << bsel);
		clr_last  = (clr_q == GAW'(GD - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_rst)
			clr_q <= '0;
		else if (cmd.clr_wr)
			clr_q <= clr_last ? '0 : clr_q + GAW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			grid_mem[clr_q] <= '0;
		else if (cmd.commit)
			grid_mem[gaddr] <= gword_new;
		if (cmd.grid_rd)
			gword_q <= grid_mem[gaddr];
	end

	// turn and move
	logic [HEAD_W-1:0] hd_new;
	logic [COL_W-1:0]  c_new;
	logic [ROW_W-1:0]  r_new;
	logic [CCNT_W-1:0] c_inc;
	logic [RCNT_W-1:0] r_inc;
	logic [COL_W-1:0]  c_last;
	logic [ROW_W-1:0]  r_last;

	always_comb begin
		hd_new = cell_bit ? (ant_hd_q + HEAD_W'(3)) : (ant_hd_q + HEAD_W'(1));
		c_inc  = CCNT_W'(c_q) + CCNT_W'(1);
		r_inc  = RCNT_W'(r_q) + RCNT_W'(1);
		c_last = COL_W'(cols_eff - CCNT_W'(1));
		r_last = ROW_W'(rows_eff - RCNT_W'(1));
		c_new  = c_q;
		r_new  = r_q;
		case (hd_new)
			HD_UP:    r_new = (r_q == '0) ? r_last : r_q - ROW_W'(1);
			HD_RIGHT: c_new = (c_inc >= cols_eff) ? '0 : COL_W'(c_inc);
			HD_DOWN:  r_new = (r_inc >= rows_eff) ? '0 : ROW_W'(r_inc);
			HD_LEFT:  c_new = (c_q == '0) ? c_last : c_q - COL_W'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_wr && slot_ok) begin
			ant_col_mem[AW'(ant_slot)]   <= COL_W'(x_cl);
			ant_row_mem[AW'(ant_slot)]   <= ROW_W'(y_cl);
			ant_hd_mem[AW'(ant_slot)]    <= start_heading;
			ant_paint_mem[AW'(ant_slot)] <= ant_rgb;
		end else if (cmd.commit) begin
			ant_col_mem[a_q[AW-1:0]] <= c_new;
			ant_row_mem[a_q[AW-1:0]] <= r_new;
			ant_hd_mem[a_q[AW-1:0]]  <= hd_new;
		end
		// the next ant is read while the current one is written back
		if (cmd.cnt_rst || cmd.commit) begin
			ant_col_q   <= ant_col_mem[ant_raddr];
			ant_row_q   <= ant_row_mem[ant_raddr];
			ant_hd_q    <= ant_hd_mem[ant_raddr];
			ant_paint_q <= ant_paint_mem[ant_raddr];
		end
	end

	// output register
	logic                   out_valid_q;
	logic [PIX_IDX_W-1:0]   out_idx_q;
	logic [PIX_COLOR_W-1:0] out_color_q;
	logic                   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (pixel_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_idx_q   <= PIX_IDX_W'(idx_q);
			out_color_q <= cell_bit ? BLACK_ARGB : (BLACK_ARGB | PIX_COLOR_W'(ant_paint_q));
			out_last_q  <= last_ant;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_index = out_idx_q;
	assign pixel_color = out_color_q;
	assign last_write  = out_last_q;

	always_comb begin
		sts.n_zero   = (n_eff == '0);
		sts.in_range = (CCNT_W'(ant_col_q) < cols_eff) && (RCNT_W'(ant_row_q) < rows_eff);
		sts.mod_done = c_done && r_done;
		sts.last_ant = last_ant;
		sts.out_free = !out_valid_q || pixel_ready;
		sts.clr_last = clr_last;
	end

	logic pos_ok;

	assign pos_ok = (CCNT_W'(c_q) < cols_eff) && (RCNT_W'(r_q) < rows_eff);

	`MAT_ASSERT_IMP(a_no_overwrite, cmd.commit, !out_valid_q || pixel_ready, "pixel overwritten")
	`MAT_ASSERT_IMP(a_pos_in_grid, cmd.commit, pos_ok, "position outside grid")
	`MAT_ASSERT_IMP(a_one_grid_write, cmd.clr_wr, !cmd.commit && !cmd.grid_rd, "grid port conflict")
	`MAT_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_q, "commit lost")

endmodule

`default_nettype wire

FILE: src/mat_ctrl.sv
`default_nettype none

module mat_ctrl import mat_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire logic [OP_W-1:0] operation,
	input  wire sts_t            sts,
	output cmd_t                 cmd
);

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_POS  = 7'b0000100,
		S_MOD  = 7'b0001000,
		S_IDX  = 7'b0010000,
		S_RD   = 7'b0100000,
		S_WR   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR; // grid is swept clear after reset
		else
			state_q <= state_nxt;
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					case (operation)
						OP_CLEAR: begin
							cmd.clr_rst = 1'b1;
							state_nxt   = S_CLR;
						end
						OP_LOAD: cmd.ld_wr = 1'b1;
						OP_STEP: begin
							if (!sts.n_zero) begin
								cmd.cnt_rst = 1'b1;
								state_nxt   = S_POS;
							end
						end
						default: ;
					endcase
				end
			end
			S_POS: begin
				cmd.pos_ld = 1'b1;
				if (sts.in_range) begin
					state_nxt = S_RD;
				end else begin
					cmd.mod_start = 1'b1;
					state_nxt     = S_MOD;
				end
			end
			S_MOD: begin
				if (sts.mod_done)
					state_nxt = S_IDX;
			end
			S_IDX: begin
				cmd.idx_ld = 1'b1;
				state_nxt  = S_RD;
			end
			S_RD: begin
				cmd.grid_rd = 1'b1;
				state_nxt   = S_WR;
			end
			S_WR: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = sts.last_ant ? S_IDLE : S_POS;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/multi_ant_turmite_step_core.sv
// Step: accepted in the idle state, then per ant a position/index multiply, a grid word
//   read and a write-back when the ant lies inside the grid; an ant outside a shrunken grid
//   adds a bit-serial remainder and an index step. Write-back waits for a free pixel output.
// Load and unknown requests finish when accepted. Clear: sweeps all MAX_COLS*MAX_ROWS/32 grid words.
// Reset: async; config back to 256 x 256 with 16 ants, then a sweep of all
//   MAX_COLS*MAX_ROWS/32 grid words zeroes the grid before the first request is taken.
`default_nettype none

module multi_ant_turmite_step_core import mat_pkg::*; #(
	parameter int MAX_ANTS = 16,
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mat_item_if.sink     item,
	mat_pixel_if.source  pixel,
	mat_cfg_if.sink      cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	mat_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.operation  (item.operation),
		.sts        (sts),
		.cmd        (cmd)
	);

	mat_dp #(
		.MAX_ANTS (MAX_ANTS),
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.ant_slot      (item.ant_slot),
		.start_x       (item.start_x),
		.start_y       (item.start_y),
		.start_heading (item.start_heading),
		.ant_rgb       (item.ant_rgb),
		.pixel_valid   (pixel.valid),
		.pixel_ready   (pixel.ready),
		.pixel_index   (pixel.pixel_index),
		.pixel_color   (pixel.pixel_color),
		.last_write    (pixel.last_write)
	);

endmodule

`default_nettype wire
